// File: src/rle_ascii_count_encoder_defines.svh
// Assertion macros shared by the front and queue modules of the run-length encoder.
`ifndef RLE_ASCII_COUNT_ENCODER_DEFINES_SVH
`define RLE_ASCII_COUNT_ENCODER_DEFINES_SVH
`ifndef SYNTHESIS
`define RLE_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("rle: implication check failed");
`define RLE_ASSERT_NXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("rle: next-cycle check failed");
`define RLE_ASSERT_NEVER(lbl, a) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(a)) \
        else $error("rle: forbidden condition seen");
`else
`define RLE_ASSERT_IMP(lbl, a, b)
`define RLE_ASSERT_NXT(lbl, a, b)
`define RLE_ASSERT_NEVER(lbl, a)
`endif
`endif

// File: src/rle_pkg.sv
// Types, constants and the digit split function of the run-length encoder.
package rle_pkg;

    localparam logic [7:0] MAX_RUN_RESET = 8'd255;
    localparam logic [3:0] ASCII_DIGIT_HI = 4'h3;

    // One closed run waiting to be written out.
    typedef struct packed {
        logic [7:0] len;
        logic [7:0] run_byte;
        logic       last;
    } run_rec_t;

    // Up to two run records per accepted input.
    typedef struct packed {
        logic     wr0;
        logic     wr1;
        run_rec_t rec0;
        run_rec_t rec1;
    } push_req_t;

    // Decimal digits, most significant first, no leading zeros.
    typedef struct packed {
        logic [1:0] count;
        logic [3:0] d0;
        logic [3:0] d1;
        logic [3:0] d2;
    } digits_t;

    function automatic digits_t to_digits(input logic [7:0] v);
        logic [19:0] sh;
        digits_t     r;
        sh = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (sh[11:8] >= 4'd5) sh[11:8] = sh[11:8] + 4'd3;
            if (sh[15:12] >= 4'd5) sh[15:12] = sh[15:12] + 4'd3;
            if (sh[19:16] >= 4'd5) sh[19:16] = sh[19:16] + 4'd3;
            sh = {sh[18:0], 1'b0};
        end
        if (sh[19:16] != 4'd0) begin
            r.count = 2'd3;
            r.d0    = sh[19:16];
            r.d1    = sh[15:12];
            r.d2    = sh[11:8];
        end
        else if (sh[15:12] != 4'd0) begin
            r.count = 2'd2;
            r.d0    = sh[15:12];
            r.d1    = sh[11:8];
            r.d2    = 4'd0;
        end
        else begin
            r.count = 2'd1;
            r.d0    = sh[11:8];
            r.d1    = 4'd0;
            r.d2    = 4'd0;
        end
        return r;
    endfunction

endpackage

// File: src/rle_front.sv
// Front end: run tracking, limit register and run record generation.
`include "rle_ascii_count_encoder_defines.svh"
module rle_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        data_byte,
    input  logic              end_of_block,
    input  logic              cfg_wr_en,
    input  logic [7:0]        cfg_wr_data,
    input  logic              queue_full,
    output rle_pkg::push_req_t req
);
    import rle_pkg::*;

    logic [7:0] max_run_reg;
    logic [7:0] run_byte_reg, run_byte_next;
    logic [7:0] run_len_reg, run_len_next;
    logic       accept;
    logic       close_run;
    logic [7:0] new_byte;
    logic [7:0] new_len;

    assign full   = queue_full;
    assign accept = push && !queue_full;

    always_comb
    begin
        close_run = 1'b0;
        new_byte  = data_byte;
        new_len   = 8'd1;
        if (run_len_reg == 8'd0) begin
            new_len = 8'd1;
        end
        else if (data_byte == run_byte_reg && run_len_reg < max_run_reg) begin
            new_byte = run_byte_reg;
            new_len  = run_len_reg + 8'd1;
        end
        else begin
            close_run = 1'b1;
        end
    end

    // Closed run goes first, the block-end run second.
    always_comb
    begin
        req.rec0.len      = close_run ? run_len_reg : new_len;
        req.rec0.run_byte = close_run ? run_byte_reg : new_byte;
        req.rec0.last     = !close_run;
        req.rec1.len      = new_len;
        req.rec1.run_byte = new_byte;
        req.rec1.last     = 1'b1;
        req.wr0           = accept && (close_run || end_of_block);
        req.wr1           = accept && close_run && end_of_block;
    end

    always_comb
    begin
        run_byte_next = run_byte_reg;
        run_len_next  = run_len_reg;
        if (accept) begin
            run_byte_next = new_byte;
            run_len_next  = end_of_block ? 8'd0 : new_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_run_reg  <= MAX_RUN_RESET;
            run_byte_reg <= 8'd0;
            run_len_reg  <= 8'd0;
        end
        else begin
            if (cfg_wr_en) begin
                max_run_reg <= cfg_wr_data;
            end
            run_byte_reg <= run_byte_next;
            run_len_reg  <= run_len_next;
        end
    end

    `RLE_ASSERT_NXT(a_eob_closes, accept && end_of_block, run_len_reg == 8'd0)
    `RLE_ASSERT_IMP(a_two_recs, req.wr1, req.wr0 && !req.rec0.last && req.rec1.last)
    `RLE_ASSERT_IMP(a_no_push_when_full, queue_full, !req.wr0 && !req.wr1)

endmodule

// File: src/rle_fifo.sv
// Run record queue between front and back, up to two writes per cycle.
`include "rle_ascii_count_encoder_defines.svh"
module rle_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  rle_pkg::push_req_t req,
    output logic              queue_full,
    output logic              queue_empty,
    input  logic              rd_en,
    output rle_pkg::run_rec_t rd_data
);
    import rle_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    run_rec_t      mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic [PW-1:0] wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PW'(1);
    // Leave room for two records so one accept never overflows.
    assign queue_full   = count_reg > CW'(DEPTH - 2);
    assign queue_empty  = count_reg == CW'(0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(req.wr0) + PW'(req.wr1);
        rd_ptr_next = rd_ptr_reg + PW'(rd_en);
        count_next  = count_reg + CW'(req.wr0) + CW'(req.wr1) - CW'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        if (req.wr0) begin
            mem_reg[wr_ptr_reg] <= req.rec0;
        end
        if (req.wr1) begin
            mem_reg[wr_ptr_plus1] <= req.rec1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `RLE_ASSERT_NEVER(a_count_range, count_reg > CW'(DEPTH))
    `RLE_ASSERT_NEVER(a_read_empty, rd_en && queue_empty)
    `RLE_ASSERT_IMP(a_ptr_gap, count_reg == CW'(0), wr_ptr_reg == rd_ptr_reg)

endmodule

// File: src/rle_back.sv
// Back end: expands run records into ASCII count digits and the run byte.
module rle_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              queue_empty,
    output logic              rd_en,
    input  rle_pkg::run_rec_t rd_data,
    output logic              empty,
    input  logic              pop,
    output logic [7:0]        out_byte,
    output logic              out_last
);
    import rle_pkg::*;

    logic       rec_valid_reg, rec_valid_next;
    logic [1:0] pos_reg, pos_next;
    logic [1:0] ndig_reg, ndig_next;
    logic [3:0] d0_reg, d1_reg, d2_reg;
    logic [3:0] d0_next, d1_next, d2_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_last_reg, out_last_next;

    digits_t    dig;
    logic       out_load;
    logic       emit;
    logic       rec_done;
    logic [3:0] cur_digit;
    logic [7:0] cur_byte;
    logic       cur_last;

    assign dig      = to_digits(rd_data.len);
    assign out_load = !out_valid_reg || pop;
    assign emit     = out_load && rec_valid_reg;
    assign rec_done = emit && (pos_reg == ndig_reg);
    assign rd_en    = (!rec_valid_reg || rec_done) && !queue_empty;

    assign empty    = !out_valid_reg;
    assign out_byte = out_byte_reg;
    assign out_last = out_last_reg;

    always_comb
    begin
        unique case (pos_reg)
            2'd0:    cur_digit = d0_reg;
            2'd1:    cur_digit = d1_reg;
            default: cur_digit = d2_reg;
        endcase
        if (pos_reg == ndig_reg) begin
            cur_byte = byte_reg;
            cur_last = last_reg;
        end
        else begin
            cur_byte = {ASCII_DIGIT_HI, cur_digit};
            cur_last = 1'b0;
        end
    end

    // Load the next record when none is held or as the current one hands over its run byte.
    always_comb
    begin
        rec_valid_next = rec_valid_reg;
        pos_next       = pos_reg;
        ndig_next      = ndig_reg;
        d0_next        = d0_reg;
        d1_next        = d1_reg;
        d2_next        = d2_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        if (rd_en) begin
            rec_valid_next = 1'b1;
            pos_next       = 2'd0;
            ndig_next      = dig.count;
            d0_next        = dig.d0;
            d1_next        = dig.d1;
            d2_next        = dig.d2;
            byte_next      = rd_data.run_byte;
            last_next      = rd_data.last;
        end
        else if (rec_done) begin
            rec_valid_next = 1'b0;
        end
        else if (emit) begin
            pos_next = pos_reg + 2'd1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (out_load) begin
            out_valid_next = emit;
            out_byte_next  = cur_byte;
            out_last_next  = cur_last;
        end
    end

    always_ff @(posedge clk)
    begin
        ndig_reg     <= ndig_next;
        d0_reg       <= d0_next;
        d1_reg       <= d1_next;
        d2_reg       <= d2_next;
        byte_reg     <= byte_next;
        last_reg     <= last_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rec_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else begin
            rec_valid_reg <= rec_valid_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: src/rle_ascii_count_encoder.sv
// Top level of the run-length encoder with ASCII decimal counts.
//
//  channel   ports                              transfer when
//  input     push, full, data_byte, end_of_block   push && !full
//  result    empty, pop, out_byte, out_last        pop && !empty
//  config    cfg_wr_en, cfg_wr_data                cfg_wr_en
//
// The front takes one byte per cycle while the run queue has room for two
// records; the back writes one output byte per cycle while the output is popped
// (1 to 3 digits plus the run byte per run), so the output side sets the sustained rate.
// A closed run passes the run queue, record registers and output register.
// Reset is asynchronous and needs no clearing pass; either side may stall
// independently, the queue and the output register absorb the difference.
module rle_ascii_count_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] data_byte,
    input  logic       end_of_block,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       out_last,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data
);
    import rle_pkg::*;

    push_req_t req;
    run_rec_t  rd_data;
    logic      queue_full;
    logic      queue_empty;
    logic      rd_en;

    rle_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .end_of_block (end_of_block),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .queue_full   (queue_full),
        .req          (req)
    );

    rle_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .queue_full  (queue_full),
        .queue_empty (queue_empty),
        .rd_en       (rd_en),
        .rd_data     (rd_data)
    );

    rle_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (queue_empty),
        .rd_en       (rd_en),
        .rd_data     (rd_data),
        .empty       (empty),
        .pop         (pop),
        .out_byte    (out_byte),
        .out_last    (out_last)
    );

endmodule

// File: tb/tb_rle_ascii_count_encoder.sv
// Testbench for the run-length encoder with ASCII decimal counts.
`timescale 1ns / 1ps

module tb_rle_ascii_count_encoder;

    localparam int         CLK_HALF     = 5;
    localparam int         RESET_CYCLES = 7;
    localparam int         DRAIN_CYCLES = 10;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         LONG_HOLD    = 300;
    localparam int         HOLD_TRIGGER = 40;
    localparam logic [7:0] ASCII_ZERO   = 8'h30;

    typedef struct packed {
        logic [7:0] data;
        logic       eob;
    } raw_byte_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } out_sym_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] data_byte;
    logic       end_of_block;
    logic       empty;
    logic       pop;
    logic [7:0] out_byte;
    logic       out_last;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    raw_byte_t  byte_stream[$];
    out_sym_t   expected_out[$];

    // encoder state as predicted by the testbench
    logic [7:0] run_byte_q   = 8'd0;
    logic [7:0] run_len_q    = 8'd0;
    logic [7:0] max_len_cfg  = 8'd255;

    bit         item_taken   = 1'b0;
    bit         calm         = 1'b0;
    bit         long_hold_done = 1'b0;
    int         items_accepted = 0;
    int         send_gap     = 0;
    int         pop_gap      = 0;
    int         long_hold_left = 0;
    int         errors       = 0;
    int         cycle_count  = 0;
    logic [7:0] last_run_byte = 8'd0;

    rle_ascii_count_encoder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .data_byte    (data_byte),
        .end_of_block (end_of_block),
        .empty        (empty),
        .pop          (pop),
        .out_byte     (out_byte),
        .out_last     (out_last),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #(CLK_HALF) clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Append one closed run: count digits, then the run byte.
    task automatic add_run_symbols(input logic [7:0] len, input logic [7:0] b,
                                   input logic last);
        out_sym_t s;
        s.last = 1'b0;
        if (len >= 8'd100) begin
            s.value = ASCII_ZERO + len / 8'd100;
            expected_out.push_back(s);
            s.value = ASCII_ZERO + (len / 8'd10) % 8'd10;
            expected_out.push_back(s);
        end
        else if (len >= 8'd10) begin
            s.value = ASCII_ZERO + len / 8'd10;
            expected_out.push_back(s);
        end
        s.value = ASCII_ZERO + len % 8'd10;
        expected_out.push_back(s);
        s.value = b;
        s.last  = last;
        expected_out.push_back(s);
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic eob);
        if (run_len_q == 8'd0) begin
            run_byte_q = b;
            run_len_q  = 8'd1;
        end
        else if (b == run_byte_q && run_len_q < max_len_cfg) begin
            run_len_q = run_len_q + 8'd1;
        end
        else begin
            add_run_symbols(run_len_q, run_byte_q, 1'b0);
            run_byte_q = b;
            run_len_q  = 8'd1;
        end
        if (eob) begin
            add_run_symbols(run_len_q, run_byte_q, 1'b1);
            run_len_q = 8'd0;
        end
    endtask

    // Check output transfers, then predict for input transfers.
    always @(posedge clk) begin
        out_sym_t e;
        if (rst_n) begin
            if (pop && !empty) begin
                if (expected_out.size() == 0) begin
                    $error("out_byte: no output expected, got %h (out_last %b)",
                           out_byte, out_last);
                    errors++;
                end
                else begin
                    e = expected_out.pop_front();
                    if (out_byte !== e.value) begin
                        $error("out_byte: expected %h, actual %h", e.value, out_byte);
                        errors++;
                    end
                    if (out_last !== e.last) begin
                        $error("out_last: expected %b, actual %b", e.last, out_last);
                        errors++;
                    end
                end
            end
            if (push && !full) begin
                encode_byte(data_byte, end_of_block);
                items_accepted++;
                item_taken = 1'b1;
            end
        end
    end

    // Input driver: hold the item until transferred, then maybe idle.
    always @(negedge clk) begin
        logic      push_nxt;
        raw_byte_t it;
        if (rst_n) begin
            push_nxt = push;
            if (item_taken) begin
                push_nxt   = 1'b0;
                item_taken = 1'b0;
            end
            if (!push_nxt) begin
                if (send_gap > 0) begin
                    send_gap--;
                end
                else if (byte_stream.size() > 0) begin
                    it = byte_stream.pop_front();
                    data_byte    <= it.data;
                    end_of_block <= it.eob;
                    push_nxt     = 1'b1;
                    send_gap     = pick_gap();
                end
            end
            push <= push_nxt;
        end
    end

    // Output side: random stalls plus one long hold-off.
    always @(negedge clk) begin
        if (rst_n) begin
            if (!long_hold_done && items_accepted >= HOLD_TRIGGER) begin
                long_hold_done = 1'b1;
                long_hold_left = LONG_HOLD;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                pop <= 1'b0;
            end
            else if (pop_gap > 0) begin
                pop_gap--;
                pop <= 1'b0;
            end
            else begin
                pop <= 1'b1;
                pop_gap = pick_gap();
            end
        end
    end

    task automatic add_run(input logic [7:0] b, input int len, input logic eob_end);
        raw_byte_t it;
        for (int i = 0; i < len; i++) begin
            it.data = b;
            it.eob  = eob_end && (i == len - 1);
            byte_stream.push_back(it);
        end
    endtask

    // Mostly well-formed runs with random content, some single noise bytes.
    task automatic add_random_blocks(input int n);
        int         count;
        int         len;
        int         r;
        logic [7:0] b;
        raw_byte_t  it;
        count = 0;
        while (count < n) begin
            if ($urandom_range(0, 9) < 8) begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    b = 8'($urandom_range(0, 255));
                else if (r == 7)
                    b = last_run_byte;
                else if (r == 8)
                    b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                else
                    b = ASCII_ZERO + 8'($urandom_range(0, 9));
                r = $urandom_range(0, 9);
                if (r < 7)
                    len = $urandom_range(1, 4);
                else if (r < 9)
                    len = $urandom_range(5, 15);
                else
                    len = $urandom_range(16, 40);
                add_run(b, len, $urandom_range(0, 9) < 3);
                last_run_byte = b;
                count += len;
            end
            else begin
                it.data = 8'($urandom_range(0, 255));
                it.eob  = 1'($urandom_range(0, 1));
                byte_stream.push_back(it);
                count++;
            end
        end
    endtask

    // Wait until every item is transferred and every output has arrived.
    task automatic wait_drained();
        while (!(byte_stream.size() == 0 && !push && expected_out.size() == 0))
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic start_phase(input logic [7:0] max_len, input bit calm_mode);
        wait_drained();
        @(posedge clk);
        calm = calm_mode;
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= max_len;
        max_len_cfg = max_len;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL rle_ascii_count_encoder");
        $finish;
    end

    initial begin
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        data_byte    = 8'd0;
        end_of_block = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = 8'd0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: no open run, bit extremes, digit bytes, eob closing a run
        start_phase(8'd255, 1'b0);
        add_run(8'h00, 1, 1'b1);
        add_run(8'hFF, 2, 1'b1);
        add_run(8'h30, 1, 1'b0);
        add_run(8'h31, 3, 1'b0);
        add_run(8'h32, 1, 1'b1);
        add_run(8'hAA, 1, 1'b0);
        add_run(8'h55, 1, 1'b1);
        add_run(8'h7F, 3, 1'b0);
        add_run(8'h80, 2, 1'b1);
        add_run(8'h5A, 10, 1'b1);
        add_run(8'h01, 1, 1'b1);

        // every byte is its own run; the long hold-off lands here
        start_phase(8'd1, 1'b0);
        add_random_blocks(40);

        // out-of-range zero acts as one
        start_phase(8'd0, 1'b0);
        add_random_blocks(20);

        start_phase(8'd2, 1'b1);
        add_random_blocks(20);

        // leave a run of ten open, then lower the cap below it
        start_phase(8'd10, 1'b0);
        add_random_blocks(20);
        add_run(8'hC3, 10, 1'b0);
        start_phase(8'd9, 1'b0);
        add_run(8'hC3, 3, 1'b1);
        add_random_blocks(15);

        start_phase(8'd107, 1'b0);
        add_run(8'h41, 110, 1'b1);

        start_phase(8'($urandom_range(1, 255)), 1'b0);
        add_random_blocks(40);
        start_phase(8'($urandom_range(1, 255)), 1'b0);
        add_random_blocks(40);

        start_phase(8'd255, 1'b1);
        add_random_blocks(30);

        wait_drained();
        if (errors == 0)
            $display("PASS rle_ascii_count_encoder");
        else
            $display("FAIL rle_ascii_count_encoder");
        $finish;
    end

endmodule
